[rtl/gdfw_pkg.sv]
// Shared types for the depth-first graph walker: word layouts, sequencer
// step, action and jump codes, and the microcode table. No dependencies.
`default_nettype none

package gdfw_pkg;

  localparam int NODES_DEF = 16;
  localparam int EDGES_DEF = 64;
  localparam int VERTEX_W  = 4;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [VERTEX_W-1:0] edge_from;
    logic [VERTEX_W-1:0] edge_to;
    logic [VERTEX_W-1:0] start_node;
  } item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] visit_node;
    logic [VERTEX_W-1:0] parent_of_node;
    logic                last_of_run;
    logic                edge_dropped;
  } result_t;

  // Program addresses
  typedef enum logic [4:0] {
    S_INIT     = 5'd0,
    S_IDLE     = 5'd1,
    S_DISPATCH = 5'd2,
    S_EDGE     = 5'd3,
    S_STORE    = 5'd4,
    S_DROP     = 5'd5,
    S_RUN      = 5'd6,
    S_CLR      = 5'd7,
    S_PUSH0    = 5'd8,
    S_POP      = 5'd9,
    S_HEAD     = 5'd10,
    S_LOADE    = 5'd11,
    S_TEST     = 5'd12,
    S_VIS      = 5'd13,
    S_PUSH     = 5'd14,
    S_PAR      = 5'd15,
    S_EMIT     = 5'd16,
    S_DONE     = 5'd17
  } step_t;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_IDLE,
    ACT_INIT_HEAD,
    ACT_READ_HEAD,
    ACT_STORE_EDGE,
    ACT_EMIT_DROP,
    ACT_CLR_START,
    ACT_CLR_VIS,
    ACT_PUSH_START,
    ACT_POP,
    ACT_HEAD_OF_CUR,
    ACT_LOAD_E,
    ACT_READ_EDGE,
    ACT_READ_VIS,
    ACT_PUSH_NB,
    ACT_READ_PAR,
    ACT_EMIT_VISIT
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_IS_RUN,
    C_EDGE_BAD,
    C_START_BAD,
    C_MORE_I,
    C_E_NULL,
    C_SP_NONZERO
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t uw(act_t a, cond_t c, step_t t);
    ucode_t w;
    w.act    = a;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // Jump to target when the condition holds, else fall through to the next step
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      S_INIT:     w = uw(ACT_INIT_HEAD,   C_MORE_I,     S_INIT);
      S_IDLE:     w = uw(ACT_IDLE,        C_NO_ITEM,    S_IDLE);
      S_DISPATCH: w = uw(ACT_NONE,        C_IS_RUN,     S_RUN);
      S_EDGE:     w = uw(ACT_READ_HEAD,   C_EDGE_BAD,   S_DROP);
      S_STORE:    w = uw(ACT_STORE_EDGE,  C_ALWAYS,     S_IDLE);
      S_DROP:     w = uw(ACT_EMIT_DROP,   C_ALWAYS,     S_IDLE);
      S_RUN:      w = uw(ACT_CLR_START,   C_START_BAD,  S_IDLE);
      S_CLR:      w = uw(ACT_CLR_VIS,     C_MORE_I,     S_CLR);
      S_PUSH0:    w = uw(ACT_PUSH_START,  C_NEVER,      S_IDLE);
      S_POP:      w = uw(ACT_POP,         C_NEVER,      S_IDLE);
      S_HEAD:     w = uw(ACT_HEAD_OF_CUR, C_NEVER,      S_IDLE);
      S_LOADE:    w = uw(ACT_LOAD_E,      C_NEVER,      S_IDLE);
      S_TEST:     w = uw(ACT_READ_EDGE,   C_E_NULL,     S_PAR);
      S_VIS:      w = uw(ACT_READ_VIS,    C_NEVER,      S_IDLE);
      S_PUSH:     w = uw(ACT_PUSH_NB,     C_ALWAYS,     S_TEST);
      S_PAR:      w = uw(ACT_READ_PAR,    C_NEVER,      S_IDLE);
      S_EMIT:     w = uw(ACT_EMIT_VISIT,  C_SP_NONZERO, S_POP);
      S_DONE:     w = uw(ACT_NONE,        C_ALWAYS,     S_IDLE);
      default:    w = uw(ACT_NONE,        C_ALWAYS,     S_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/gdfw_stream_if.sv]
// Valid/ready stream channel carrying one word of payload_t.
// No dependencies; the payload type is set where the channel is instantiated.
`default_nettype none

interface gdfw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/graph_depth_first_walk.sv]
// Depth-first graph walker: a microcoded step sequencer over small memories.
// Depends on gdfw_pkg (types, microcode table) and gdfw_stream_if.
`default_nettype none

// An edge word passes through the dispatch and edge steps and then is stored or
// dropped; a dropped edge also waits for the result hand-off. A run word first
// clears the visited marks, then pops vertices and scans each one's stored
// edges, with one memory access per step of the program; a stalled result
// holds the sequencer. After reset the block clears the list heads, with
// items.ready low, before it takes its first word. One word is worked on at a
// time; a finished result waits in an output register.
module graph_depth_first_walk
  import gdfw_pkg::*;
#(
  parameter int NODES = NODES_DEF,
  parameter int EDGES = EDGES_DEF
) (
  input  wire               clk,
  input  wire               rst,
  gdfw_stream_if.sink       items,
  gdfw_stream_if.source     results
);

  localparam int NW  = $clog2(NODES);
  localparam int EAW = $clog2(EDGES);
  localparam int EW  = $clog2(EDGES + 1);
  localparam int SW  = $clog2(NODES + 1);
  localparam logic [EW-1:0] NULL_E = EW'(EDGES);

  // sequencer and control state
  step_t          pc, pc_next;
  logic [NW-1:0]  idx;
  logic [EW-1:0]  edge_count;
  logic [SW-1:0]  sp;
  logic           out_valid;

  // datapath
  item_t          item;
  result_t        out_q;
  logic [NW-1:0]  cur, tgt;
  logic [EW-1:0]  e;

  // memories and their read registers
  logic [EW-1:0]  list_head   [NODES];
  logic [NW-1:0]  edge_target [EDGES];
  logic [EW-1:0]  edge_link   [EDGES];
  logic           visited     [NODES];
  logic [NW-1:0]  parent_mem  [NODES];
  logic [NW-1:0]  stack_mem   [NODES];
  logic [EW-1:0]  head_rd, link_rd;
  logic [NW-1:0]  tgt_rd, par_rd, stack_rd;
  logic           vis_rd;

  ucode_t         ucw;
  logic           is_emit, out_free, go, jump;
  logic           edge_bad, start_bad;
  logic [NW-1:0]  from_n, to_n, start_n;

  always_comb begin
    ucw       = ucode_rom(pc);
    out_free  = !out_valid || results.ready;
    is_emit   = (ucw.act == ACT_EMIT_DROP) || (ucw.act == ACT_EMIT_VISIT);
    go        = !(is_emit && !out_free);
    from_n    = NW'(item.edge_from);
    to_n      = NW'(item.edge_to);
    start_n   = NW'(item.start_node);
    edge_bad  = (32'(item.edge_from) >= NODES) || (32'(item.edge_to) >= NODES) ||
                (32'(edge_count) >= EDGES);
    start_bad = 32'(item.start_node) >= NODES;
  end

  always_comb begin
    unique case (ucw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_ITEM:    jump = !items.valid;
      C_IS_RUN:     jump = item.kind == KIND_RUN;
      C_EDGE_BAD:   jump = edge_bad;
      C_START_BAD:  jump = start_bad;
      C_MORE_I:     jump = 32'(idx) != NODES - 1;
      C_E_NULL:     jump = e == NULL_E;
      C_SP_NONZERO: jump = sp != '0;
      default:      jump = 1'b0;
    endcase
    if (!go) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = ucw.target;
    end else begin
      pc_next = step_t'(5'(pc) + 5'd1);
    end
  end

  assign items.ready   = ucw.act == ACT_IDLE;
  assign results.valid = out_valid;
  assign results.data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= S_INIT;
      idx        <= '0;
      edge_count <= '0;
      sp         <= '0;
      out_valid  <= 1'b0;
    end else begin
      pc <= pc_next;
      if (go && is_emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (go) begin
        unique case (ucw.act)
          ACT_INIT_HEAD,
          ACT_CLR_VIS:    idx <= idx + 1'b1;
          ACT_CLR_START:  idx <= '0;
          ACT_STORE_EDGE: edge_count <= edge_count + 1'b1;
          ACT_PUSH_START: sp <= SW'(1);
          ACT_POP:        sp <= sp - 1'b1;
          ACT_PUSH_NB:    if (!vis_rd) sp <= sp + 1'b1;
          default: ;
        endcase
      end
    end
  end

  // Datapath and memories: one access per memory per step
  always_ff @(posedge clk) begin
    if (go) begin
      unique case (ucw.act)
        ACT_IDLE: begin
          if (items.valid) item <= items.data;
        end
        ACT_INIT_HEAD:  list_head[idx] <= NULL_E;
        ACT_READ_HEAD:  head_rd <= list_head[from_n];
        ACT_STORE_EDGE: begin
          // new edge goes in front of its source's list
          edge_target[EAW'(edge_count)] <= to_n;
          edge_link[EAW'(edge_count)]   <= head_rd;
          list_head[from_n]             <= edge_count;
        end
        ACT_EMIT_DROP: begin
          out_q.visit_node     <= '0;
          out_q.parent_of_node <= '0;
          out_q.last_of_run    <= 1'b0;
          out_q.edge_dropped   <= 1'b1;
        end
        ACT_CLR_VIS:    visited[idx] <= 1'b0;
        ACT_PUSH_START: begin
          stack_mem[0]        <= start_n;
          visited[start_n]    <= 1'b1;
          parent_mem[start_n] <= start_n;
        end
        ACT_POP:        stack_rd <= stack_mem[NW'(sp - 1'b1)];
        ACT_HEAD_OF_CUR: begin
          cur     <= stack_rd;
          head_rd <= list_head[stack_rd];
        end
        ACT_LOAD_E:     e <= head_rd;
        ACT_READ_EDGE: begin
          tgt_rd  <= edge_target[EAW'(e)];
          link_rd <= edge_link[EAW'(e)];
        end
        ACT_READ_VIS: begin
          tgt    <= tgt_rd;
          e      <= link_rd;
          vis_rd <= visited[tgt_rd];
        end
        ACT_PUSH_NB: begin
          // marked on push, so a vertex goes on the stack once per run
          if (!vis_rd) begin
            stack_mem[NW'(sp)] <= tgt;
            visited[tgt]       <= 1'b1;
            parent_mem[tgt]    <= cur;
          end
        end
        ACT_READ_PAR:   par_rd <= parent_mem[cur];
        ACT_EMIT_VISIT: begin
          out_q.visit_node     <= VERTEX_W'(cur);
          out_q.parent_of_node <= VERTEX_W'(par_rd);
          out_q.last_of_run    <= sp == '0;
          out_q.edge_dropped   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[tb/graph_depth_first_walk_tb.sv]
// Self-checking bench for graph_depth_first_walk: edge and run words go in,
// walk visits and dropped-edge flags are checked against a built-in predictor.
// Depends on gdfw_pkg, gdfw_stream_if and the graph_depth_first_walk RTL.
module graph_depth_first_walk_tb;
  import gdfw_pkg::*;

  localparam int NODES       = NODES_DEF;
  localparam int EDGES       = EDGES_DEF;
  localparam int RANDOM_RUNS = 450;
  localparam int HOLD_AT     = 360;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  gdfw_stream_if #(.payload_t(item_t))   items_ch ();
  gdfw_stream_if #(.payload_t(result_t)) results_ch ();

  graph_depth_first_walk #(
    .NODES(NODES),
    .EDGES(EDGES)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_ch),
    .results(results_ch)
  );

  // Graph and walk state kept alongside the block
  logic [6:0] first_edge [NODES] = '{default: 7'(EDGES)};
  logic [3:0] edge_dest  [EDGES];
  logic [6:0] edge_next  [EDGES];
  logic [6:0] edge_total = '0;
  logic       seen       [NODES];
  logic [3:0] came_from  [NODES];
  logic [3:0] walk_stack [NODES];
  logic [4:0] depth = '0;

  item_t   stim_q[$];
  result_t pending_visits[$];
  int      words_taken = 0;
  int      visits_seen = 0;
  int      mismatches  = 0;
  int      quiet       = 0;
  int      hold_left   = 0;
  bit      hold_done   = 1'b0;

  function automatic item_t make_item(logic k, int src, int dst, int root);
    item_t w;
    w.kind       = k;
    w.edge_from  = src[3:0];
    w.edge_to    = dst[3:0];
    w.start_node = root[3:0];
    return w;
  endfunction

  function automatic int tx_idle_pct(int n);
    return (n < 160) ? 24 : (n < 320) ? 70 : 0;
  endfunction

  function automatic int rx_idle_pct(int n);
    return (n < 160) ? 70 : (n < 320) ? 24 : 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at visit %0d: %s", visits_seen, msg);
    mismatches++;
  endtask

  // Works out every result word that one accepted word causes
  task automatic predict_results(input item_t w);
    result_t    r;
    logic [6:0] e;
    logic [3:0] cur;
    logic [3:0] t;
    int         guard;
    if (w.kind == KIND_EDGE) begin
      if (w.edge_from >= NODES || w.edge_to >= NODES || edge_total >= EDGES) begin
        r = '0;
        r.edge_dropped = 1'b1;
        pending_visits.push_back(r);
      end else begin
        edge_dest[edge_total[5:0]] = w.edge_to;
        edge_next[edge_total[5:0]] = first_edge[w.edge_from];
        first_edge[w.edge_from] = edge_total;
        edge_total = edge_total + 1'b1;
      end
    end else if (w.start_node < NODES) begin
      for (int i = 0; i < NODES; i++) seen[i] = 1'b0;
      depth = '0;
      walk_stack[depth[3:0]] = w.start_node;
      depth = depth + 1'b1;
      seen[w.start_node] = 1'b1;
      came_from[w.start_node] = w.start_node;
      while (depth != 0) begin
        depth = depth - 1'b1;
        cur = walk_stack[depth[3:0]];
        e = first_edge[cur];
        guard = 0;
        // neighbours are marked when pushed, not when popped
        while (e < EDGES && guard < EDGES) begin
          t = edge_dest[e[5:0]];
          if (!seen[t] && depth < NODES) begin
            walk_stack[depth[3:0]] = t;
            depth = depth + 1'b1;
            seen[t] = 1'b1;
            came_from[t] = cur;
          end
          e = edge_next[e[5:0]];
          guard++;
        end
        r.visit_node     = cur;
        r.parent_of_node = came_from[cur];
        r.last_of_run    = (depth == 0);
        r.edge_dropped   = 1'b0;
        pending_visits.push_back(r);
      end
    end
  endtask

  // Sender: holds a word until taken, then may idle before the next one
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      items_ch.valid <= 1'b0;
    end else begin
      offer = items_ch.valid;
      if (items_ch.valid && items_ch.ready) begin
        predict_results(items_ch.data);
        words_taken <= words_taken + 1;
        offer = 1'b0;
      end
      if (!offer && stim_q.size() != 0 && $urandom_range(99) >= tx_idle_pct(words_taken)) begin
        items_ch.data <= stim_q.pop_front();
        offer = 1'b1;
      end
      items_ch.valid <= offer;
    end
  end

  // Receiver: random back-pressure, plus one long hold so the input stalls
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      results_ch.ready <= 1'b0;
    end else if (!hold_done && words_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= ($urandom_range(99) >= rx_idle_pct(words_taken));
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && results_ch.valid && results_ch.ready) begin
      got = results_ch.data;
      if (pending_visits.size() == 0) begin
        report_mismatch($sformatf("unexpected word node=%0d parent=%0d last=%0d drop=%0d",
                                  got.visit_node, got.parent_of_node, got.last_of_run,
                                  got.edge_dropped));
      end else begin
        want = pending_visits.pop_front();
        if (got.visit_node !== want.visit_node)
          report_mismatch($sformatf("visit_node expected %0d got %0d",
                                    want.visit_node, got.visit_node));
        if (got.parent_of_node !== want.parent_of_node)
          report_mismatch($sformatf("parent_of_node expected %0d got %0d",
                                    want.parent_of_node, got.parent_of_node));
        if (got.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run expected %0d got %0d",
                                    want.last_of_run, got.last_of_run));
        if (got.edge_dropped !== want.edge_dropped)
          report_mismatch($sformatf("edge_dropped expected %0d got %0d",
                                    want.edge_dropped, got.edge_dropped));
      end
      visits_seen <= visits_seen + 1;
    end
  end

  // Watchdog on cycles where neither channel moves a word
  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) ||
        (results_ch.valid && results_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int edge_pct;

    // walks over an empty graph: start alone, its own parent, last set
    stim_q.push_back(make_item(KIND_RUN, 3, 12, 0));
    stim_q.push_back(make_item(KIND_RUN, 12, 3, 15));
    // two-vertex cycle, self loop and a duplicate edge
    stim_q.push_back(make_item(KIND_EDGE, 0, 15, 5));
    stim_q.push_back(make_item(KIND_EDGE, 15, 0, 10));
    stim_q.push_back(make_item(KIND_EDGE, 0, 0, 15));
    stim_q.push_back(make_item(KIND_EDGE, 0, 15, 0));
    stim_q.push_back(make_item(KIND_RUN, 15, 15, 0));
    stim_q.push_back(make_item(KIND_RUN, 0, 0, 15));
    stim_q.push_back(make_item(KIND_EDGE, 15, 15, 7));
    // chain with a fan-out so stack order shows in the visits
    stim_q.push_back(make_item(KIND_EDGE, 3, 7, 8));
    stim_q.push_back(make_item(KIND_EDGE, 3, 9, 1));
    stim_q.push_back(make_item(KIND_EDGE, 3, 10, 2));
    stim_q.push_back(make_item(KIND_EDGE, 7, 3, 4));
    stim_q.push_back(make_item(KIND_EDGE, 9, 10, 6));
    stim_q.push_back(make_item(KIND_EDGE, 10, 15, 11));
    stim_q.push_back(make_item(KIND_RUN, 10, 5, 3));
    stim_q.push_back(make_item(KIND_RUN, 1, 2, 7));
    stim_q.push_back(make_item(KIND_RUN, 8, 8, 10));
    // isolated vertex
    stim_q.push_back(make_item(KIND_RUN, 6, 6, 5));

    // graph is built early, then mostly walks; once the store is full,
    // every further edge word comes back dropped
    for (int i = 0; i < RANDOM_RUNS; i++) begin
      edge_pct = (i < 150) ? 50 : 20;
      stim_q.push_back(make_item(($urandom_range(99) < edge_pct) ? KIND_EDGE : KIND_RUN,
                                 $urandom_range(15), $urandom_range(15),
                                 $urandom_range(15)));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || items_ch.valid || pending_visits.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_visits.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", pending_visits.size()));

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
